// ----- rtl/stls_pkg.sv -----
// ----------------------------------------------------------------------------
// stls_pkg
// Shared constants and types for the stability latching track smoother: window
// geometry, field widths, register indexes and the divider status bundle.
// ----------------------------------------------------------------------------
package stls_pkg;

  localparam int WINDOW_SIZE = 10;
  localparam int SLOT_W      = $clog2(WINDOW_SIZE);
  localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);

  localparam int POS_W = 20;
  localparam int LEN_W = 16;
  localparam int HDG_W = 16;
  localparam int LIM_W = 16;

  // window values are held offset to unsigned, all at the widest field width
  localparam int VAL_W  = POS_W;
  localparam int SUM_W  = VAL_W + SLOT_W;

  // floor(sum / WINDOW_SIZE) as (sum * RECIP_MULT) >> RECIP_SHIFT, exact for any sum
  localparam int RECIP_SHIFT = SUM_W + SLOT_W;
  localparam int RECIP_W     = SUM_W + 1;
  localparam logic [RECIP_W-1:0] RECIP_MULT =
    RECIP_W'(((longint'(1) << RECIP_SHIFT) + longint'(WINDOW_SIZE) - longint'(1)) /
             longint'(WINDOW_SIZE));

  localparam int NFIELD = 4;
  localparam int F_X    = 0;
  localparam int F_Y    = 1;
  localparam int F_LEN  = 2;
  localparam int F_HDG  = 3;

  localparam int CFG_IDX_W = 4;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_LIMIT   = 4'd0,
    CFG_Y_LIMIT   = 4'd1,
    CFG_LEN_LIMIT = 4'd2,
    CFG_HDG_LIMIT = 4'd3
  } cfg_reg_t;

  localparam logic [LIM_W-1:0] X_LIMIT_RST   = 16'd300;
  localparam logic [LIM_W-1:0] Y_LIMIT_RST   = 16'd100;
  localparam logic [LIM_W-1:0] LEN_LIMIT_RST = 16'd300;
  localparam logic [LIM_W-1:0] HDG_LIMIT_RST = 16'd696;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic        [LEN_W-1:0] len;
    logic signed [HDG_W-1:0] hdg;
  } ring_entry_t;

endpackage

// ----- rtl/stls_div.sv -----
// ----------------------------------------------------------------------------
// stls_div
// Divides an unsigned window sum by the window size through a reciprocal
// multiply; the sum is held on start and done pulses as the quotient is registered.
// ----------------------------------------------------------------------------
module stls_div
  import stls_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  output logic [VAL_W-1:0] quotient,
  output div_stat_t        stat
);

  logic [SUM_W-1:0]         held;
  logic [SUM_W+RECIP_W-1:0] prod;

  assign prod = (SUM_W+RECIP_W)'(held) * (SUM_W+RECIP_W)'(RECIP_MULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else begin
      stat.busy <= start;
      stat.done <= stat.busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      held <= dividend;
    end
    if (stat.busy) begin
      quotient <= prod[RECIP_SHIFT +: VAL_W];
    end
  end

endmodule

// ----- rtl/stability_latching_track_smoother_top.sv -----
// ----------------------------------------------------------------------------
// stability_latching_track_smoother_top
// Smooths a line track and latches each group once its window is steady.
// ----------------------------------------------------------------------------
// Each accepted measurement is written into a ten-entry window memory. While
// the window is not yet full, or every group is already latched, a request
// goes from acceptance through the apply and done steps to the result
// register. Once the window is full and some group is still open, the
// window memory is walked one entry per cycle through its single read port
// to gather min, max and sum before the evaluate, apply and done steps. A
// request that latches a group also forms the window mean with a reciprocal
// multiply; this happens at most three times after reset. The next request
// is taken as soon as the result is placed in the output register; a result
// the receiver has not yet taken holds the following one in its last step.
module stability_latching_track_smoother_top
  import stls_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [POS_W-1:0] meas_x,
  input  logic signed [POS_W-1:0] meas_y,
  input  logic        [LEN_W-1:0] meas_length,
  input  logic signed [HDG_W-1:0] meas_heading,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [POS_W-1:0] track_x,
  output logic signed [POS_W-1:0] track_y,
  output logic        [LEN_W-1:0] track_length,
  output logic signed [HDG_W-1:0] track_heading,
  output logic                    centre_stable,
  output logic                    length_stable,
  output logic                    heading_stable,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [LIM_W-1:0]        cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WALK  = 6'b000010,
    S_EVAL  = 6'b000100,
    S_DIV   = 6'b001000,
    S_APPLY = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;

  logic [LIM_W-1:0] x_limit, y_limit, len_limit, hdg_limit;

  ring_entry_t ring [WINDOW_SIZE];
  ring_entry_t ring_q;
  logic [SLOT_W-1:0] rd_addr;

  logic [SLOT_W-1:0] write_slot;
  logic [CNT_W-1:0]  fill_count;
  logic [CNT_W-1:0]  fill_next;
  logic [CNT_W-1:0]  walk_cnt;
  logic              seeded;
  logic [2:0]        latch;
  logic [2:0]        pend;
  logic [2:0]        stable;

  logic signed [POS_W-1:0] mq_x, mq_y;
  logic        [LEN_W-1:0] mq_len;
  logic signed [HDG_W-1:0] mq_hdg;

  logic signed [POS_W-1:0] tx, ty;
  logic        [LEN_W-1:0] tlen;
  logic signed [HDG_W-1:0] thdg;

  logic [VAL_W-1:0] bv     [NFIELD];
  logic [VAL_W-1:0] vmin   [NFIELD];
  logic [VAL_W-1:0] vmax   [NFIELD];
  logic [VAL_W-1:0] spread [NFIELD];
  logic [SUM_W-1:0] vsum   [NFIELD];
  logic [VAL_W-1:0] div_q  [NFIELD];
  div_stat_t        div_stat [NFIELD];
  logic             div_start;

  logic [POS_W:0] avg_x_sum, avg_y_sum;
  logic [LEN_W:0] avg_len_sum;
  logic [HDG_W:0] avg_hdg_sum;
  logic           in_acc;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_limit   <= X_LIMIT_RST;
      y_limit   <= Y_LIMIT_RST;
      len_limit <= LEN_LIMIT_RST;
      hdg_limit <= HDG_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_X_LIMIT:   x_limit   <= cfg_data;
        CFG_Y_LIMIT:   y_limit   <= cfg_data;
        CFG_LEN_LIMIT: len_limit <= cfg_data;
        CFG_HDG_LIMIT: hdg_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // window memory, one write and one registered read port
  assign rd_addr = (walk_cnt == CNT_W'(WINDOW_SIZE)) ? '0 : walk_cnt[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ring[write_slot] <= '{x: meas_x, y: meas_y, len: meas_length, hdg: meas_heading};
    end
    ring_q <= ring[rd_addr];
  end

  // window values offset to unsigned so one compare and adder serve every field
  assign bv[F_X]   = {~ring_q.x[POS_W-1], ring_q.x[POS_W-2:0]};
  assign bv[F_Y]   = {~ring_q.y[POS_W-1], ring_q.y[POS_W-2:0]};
  assign bv[F_LEN] = VAL_W'(ring_q.len);
  assign bv[F_HDG] = VAL_W'({~ring_q.hdg[HDG_W-1], ring_q.hdg[HDG_W-2:0]});

  always_comb begin
    for (int f = 0; f < NFIELD; f++) begin
      spread[f] = vmax[f] - vmin[f];
    end
    stable[0] = (spread[F_X] < VAL_W'(x_limit)) && (spread[F_Y] < VAL_W'(y_limit));
    stable[1] = spread[F_LEN] < VAL_W'(len_limit);
    stable[2] = spread[F_HDG] < VAL_W'(hdg_limit);
  end

  assign div_start = (state == S_EVAL) && ((stable & ~latch) != 3'b000);

  for (genvar g = 0; g < NFIELD; g++) begin : g_div
    stls_div u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (div_start),
      .dividend (vsum[g]),
      .quotient (div_q[g]),
      .stat     (div_stat[g])
    );
  end

  assign fill_next   = (fill_count == CNT_W'(WINDOW_SIZE)) ? fill_count : fill_count + 1'b1;
  assign avg_x_sum   = {mq_x[POS_W-1], mq_x} + {tx[POS_W-1], tx};
  assign avg_y_sum   = {mq_y[POS_W-1], mq_y} + {ty[POS_W-1], ty};
  assign avg_len_sum = {1'b0, mq_len} + {1'b0, tlen};
  assign avg_hdg_sum = {mq_hdg[HDG_W-1], mq_hdg} + {thdg[HDG_W-1], thdg};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      write_slot <= '0;
      fill_count <= '0;
      walk_cnt   <= '0;
      seeded     <= 1'b0;
      latch      <= 3'b000;
      pend       <= 3'b000;
      out_valid  <= 1'b0;
      tx         <= '0;
      ty         <= '0;
      tlen       <= '0;
      thdg       <= '0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            mq_x       <= meas_x;
            mq_y       <= meas_y;
            mq_len     <= meas_length;
            mq_hdg     <= meas_heading;
            write_slot <= (write_slot == SLOT_W'(WINDOW_SIZE - 1)) ? '0 : write_slot + 1'b1;
            fill_count <= fill_next;
            pend       <= 3'b000;
            walk_cnt   <= '0;
            if (!seeded) begin
              tx     <= meas_x;
              ty     <= meas_y;
              tlen   <= meas_length;
              thdg   <= meas_heading;
              seeded <= 1'b1;
            end
            if (fill_next == CNT_W'(WINDOW_SIZE) && latch != 3'b111) begin
              state <= S_WALK;
            end else begin
              state <= S_APPLY;
            end
          end
        end
        S_WALK: begin
          // read data is registered, so it belongs to the address of the step before
          if (walk_cnt != '0) begin
            for (int f = 0; f < NFIELD; f++) begin
              if (walk_cnt == CNT_W'(1)) begin
                vmin[f] <= bv[f];
                vmax[f] <= bv[f];
                vsum[f] <= SUM_W'(bv[f]);
              end else begin
                if (bv[f] < vmin[f]) vmin[f] <= bv[f];
                if (bv[f] > vmax[f]) vmax[f] <= bv[f];
                vsum[f] <= vsum[f] + SUM_W'(bv[f]);
              end
            end
          end
          if (walk_cnt == CNT_W'(WINDOW_SIZE)) begin
            walk_cnt <= '0;
            state    <= S_EVAL;
          end else begin
            walk_cnt <= walk_cnt + 1'b1;
          end
        end
        S_EVAL: begin
          pend  <= stable & ~latch;
          state <= div_start ? S_DIV : S_APPLY;
        end
        S_DIV: begin
          if (div_stat[0].done) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (!latch[0]) begin
            if (pend[0]) begin
              tx <= {~div_q[F_X][POS_W-1], div_q[F_X][POS_W-2:0]};
              ty <= {~div_q[F_Y][POS_W-1], div_q[F_Y][POS_W-2:0]};
            end else begin
              tx <= avg_x_sum[POS_W:1];
              ty <= avg_y_sum[POS_W:1];
            end
          end
          if (!latch[1]) begin
            tlen <= pend[1] ? div_q[F_LEN][LEN_W-1:0] : avg_len_sum[LEN_W:1];
          end
          if (!latch[2]) begin
            thdg <= pend[2] ? {~div_q[F_HDG][HDG_W-1], div_q[F_HDG][HDG_W-2:0]}
                            : avg_hdg_sum[HDG_W:1];
          end
          latch <= latch | pend;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            track_x        <= tx;
            track_y        <= ty;
            track_length   <= tlen;
            track_heading  <= thdg;
            centre_stable  <= latch[0];
            length_stable  <= latch[1];
            heading_stable <= latch[2];
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result appeared outside the done state");

  a_latch_sticky: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ((latch & $past(latch)) == $past(latch)))
    else $error("a latched group was released");

  a_latch_in_apply: assert property (@(posedge clk) disable iff (rst)
    ((latch & ~$past(latch)) != 3'b000) |-> $past(state == S_APPLY))
    else $error("group latched outside the apply step");

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    (div_stat[0] == div_stat[1]) && (div_stat[0] == div_stat[2]) &&
    (div_stat[0] == div_stat[3]))
    else $error("mean dividers out of step");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    walk_cnt <= CNT_W'(WINDOW_SIZE))
    else $error("window walk ran past the last entry");
`endif

endmodule

// ----- sim/tb_stability_latching_track_smoother_top.sv -----
// ----------------------------------------------------------------------------
// tb_stability_latching_track_smoother_top
// Self-checking bench for the stability latching track smoother. A shadow copy
// of the smoother predicts every track result from the accepted measurements
// and the programmed spread limits. Stimulus runs from corner values through
// steady windows, noisy runs and broken runs under several limit settings,
// while the sender and the receiver both idle and stall at random.
// ----------------------------------------------------------------------------
module tb_stability_latching_track_smoother_top;
  import stls_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned HOLD_AFTER  = 300;
  localparam int unsigned TAIL_CYCLES = 60;

  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] POS_MAX = ~POS_MIN;
  localparam logic signed [HDG_W-1:0] HDG_MIN = {1'b1, {(HDG_W-1){1'b0}}};
  localparam logic signed [HDG_W-1:0] HDG_MAX = ~HDG_MIN;
  localparam logic [LEN_W-1:0]        LEN_MAX = '1;

  localparam int CFG_FIRST_UNUSED = int'(CFG_HDG_LIMIT) + 1;
  localparam int CFG_LAST_INDEX   = (1 << CFG_IDX_W) - 1;

  typedef enum int unsigned {
    RX_ALWAYS,
    RX_COIN,
    RX_RARE_STALL,
    RX_EVERY_FOURTH
  } rx_mode_t;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic        [LEN_W-1:0] len;
    logic signed [HDG_W-1:0] hdg;
  } meas_t;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic        [LEN_W-1:0] len;
    logic signed [HDG_W-1:0] hdg;
    logic                    centre;
    logic                    length;
    logic                    heading;
  } track_t;

  typedef struct {
    logic [CFG_IDX_W-1:0] idx;
    logic [LIM_W-1:0]     data;
  } cfg_write_t;

  class latching_smoother;
    longint x_lim, y_lim, len_lim, hdg_lim;
    longint ring_x[WINDOW_SIZE];
    longint ring_y[WINDOW_SIZE];
    longint ring_len[WINDOW_SIZE];
    longint ring_hdg[WINDOW_SIZE];
    int unsigned fill, slot;
    longint trk_x, trk_y, trk_len, trk_hdg;
    bit centre_lat, len_lat, hdg_lat, seeded;
    track_t expected_tracks[$];
    int unsigned noted, checked, errors;

    function new();
      x_lim = longint'(X_LIMIT_RST);
      y_lim = longint'(Y_LIMIT_RST);
      len_lim = longint'(LEN_LIMIT_RST);
      hdg_lim = longint'(HDG_LIMIT_RST);
      fill = 0;
      slot = 0;
      trk_x = 0;
      trk_y = 0;
      trk_len = 0;
      trk_hdg = 0;
      centre_lat = 0;
      len_lat = 0;
      hdg_lat = 0;
      seeded = 0;
      noted = 0;
      checked = 0;
      errors = 0;
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [LIM_W-1:0] val);
      case (idx)
        CFG_X_LIMIT:   x_lim = longint'(val);
        CFG_Y_LIMIT:   y_lim = longint'(val);
        CFG_LEN_LIMIT: len_lim = longint'(val);
        CFG_HDG_LIMIT: hdg_lim = longint'(val);
        default: ;
      endcase
    endfunction

    function longint window_spread(longint r[WINDOW_SIZE]);
      longint lo, hi;
      lo = r[0];
      hi = r[0];
      foreach (r[i]) begin
        if (r[i] < lo) lo = r[i];
        if (r[i] > hi) hi = r[i];
      end
      return hi - lo;
    endfunction

    // mean rounded toward minus infinity
    function longint window_mean(longint r[WINDOW_SIZE]);
      longint s, q;
      s = 0;
      foreach (r[i]) s += r[i];
      q = s / WINDOW_SIZE;
      if ((s % WINDOW_SIZE) != 0 && s < 0) q -= 1;
      return q;
    endfunction

    function void note_measurement(meas_t m);
      longint mx, my, ml, mh;
      bit full;
      track_t want;
      mx = longint'(m.x);
      my = longint'(m.y);
      ml = longint'(m.len);
      mh = longint'(m.hdg);
      ring_x[slot] = mx;
      ring_y[slot] = my;
      ring_len[slot] = ml;
      ring_hdg[slot] = mh;
      slot = (slot == WINDOW_SIZE - 1) ? 0 : slot + 1;
      if (fill < WINDOW_SIZE) fill++;
      full = (fill == WINDOW_SIZE);

      if (!seeded) begin
        trk_x = mx;
        trk_y = my;
        trk_len = ml;
        trk_hdg = mh;
        seeded = 1;
      end

      // x and y latch together
      if (!centre_lat) begin
        if (full && window_spread(ring_x) < x_lim && window_spread(ring_y) < y_lim) begin
          trk_x = window_mean(ring_x);
          trk_y = window_mean(ring_y);
          centre_lat = 1;
        end else begin
          trk_x = (mx + trk_x) >>> 1;
          trk_y = (my + trk_y) >>> 1;
        end
      end

      if (!len_lat) begin
        if (full && window_spread(ring_len) < len_lim) begin
          trk_len = window_mean(ring_len);
          len_lat = 1;
        end else begin
          trk_len = (ml + trk_len) >>> 1;
        end
      end

      if (!hdg_lat) begin
        if (full && window_spread(ring_hdg) < hdg_lim) begin
          trk_hdg = window_mean(ring_hdg);
          hdg_lat = 1;
        end else begin
          trk_hdg = (mh + trk_hdg) >>> 1;
        end
      end

      want.x = trk_x[POS_W-1:0];
      want.y = trk_y[POS_W-1:0];
      want.len = trk_len[LEN_W-1:0];
      want.hdg = trk_hdg[HDG_W-1:0];
      want.centre = centre_lat;
      want.length = len_lat;
      want.heading = hdg_lat;
      expected_tracks.insert(expected_tracks.size(), want);
      noted++;
    endfunction

    function void compare_field(string name, logic signed [31:0] want_v,
                                logic signed [31:0] got_v);
      if (got_v !== want_v) begin
        $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_track(track_t got);
      track_t want;
      if (expected_tracks.size() == 0) begin
        $display("%0t track result with no measurement pending: x=%0d y=%0d", $time,
                 got.x, got.y);
        errors++;
        return;
      end
      want = expected_tracks.pop_front();
      compare_field("track_x", 32'(want.x), 32'(got.x));
      compare_field("track_y", 32'(want.y), 32'(got.y));
      compare_field("track_length", 32'(want.len), 32'(got.len));
      compare_field("track_heading", 32'(want.hdg), 32'(got.hdg));
      compare_field("centre_stable", 32'(want.centre), 32'(got.centre));
      compare_field("length_stable", 32'(want.length), 32'(got.length));
      compare_field("heading_stable", 32'(want.heading), 32'(got.heading));
      checked++;
    endfunction

    function int unsigned pending();
      return expected_tracks.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [POS_W-1:0] meas_x = '0;
  logic signed [POS_W-1:0] meas_y = '0;
  logic        [LEN_W-1:0] meas_length = '0;
  logic signed [HDG_W-1:0] meas_heading = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [POS_W-1:0] track_x;
  logic signed [POS_W-1:0] track_y;
  logic        [LEN_W-1:0] track_length;
  logic signed [HDG_W-1:0] track_heading;
  logic                    centre_stable;
  logic                    length_stable;
  logic                    heading_stable;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [LIM_W-1:0]        cfg_data = '0;

  latching_smoother shadow = new();

  int unsigned burst_left = 0;
  bit          no_gaps = 1'b0;
  int unsigned results_seen = 0;
  bit          long_hold_done = 1'b0;
  int unsigned limit_sets = 0;

  stability_latching_track_smoother_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .meas_x        (meas_x),
    .meas_y        (meas_y),
    .meas_length   (meas_length),
    .meas_heading  (meas_heading),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .track_x       (track_x),
    .track_y       (track_y),
    .track_length  (track_length),
    .track_heading (track_heading),
    .centre_stable (centre_stable),
    .length_stable (length_stable),
    .heading_stable(heading_stable),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // random bits with a bias toward the corners of a w-bit field
  function automatic logic [31:0] rand_bits(int unsigned w);
    logic [31:0] ones;
    ones = (32'd1 << w) - 32'd1;
    case ($urandom_range(0, 11))
      0: return '0;
      1: return ones;
      2: return 32'd1 << (w - 1);
      3: return ones >> 1;
      default: return $urandom;
    endcase
  endfunction

  function automatic meas_t noise_meas();
    meas_t m;
    m.x = POS_W'(rand_bits(POS_W));
    m.y = POS_W'(rand_bits(POS_W));
    m.len = LEN_W'(rand_bits(LEN_W));
    m.hdg = HDG_W'(rand_bits(HDG_W));
    return m;
  endfunction

  function automatic longint around(longint base, int unsigned jit, longint lo, longint hi);
    longint v;
    v = base + longint'($urandom_range(0, 2 * jit)) - longint'(jit);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic int unsigned pick_jitter(int unsigned max_jit);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return $urandom_range(1, 20);
      default: return $urandom_range(0, max_jit);
    endcase
  endfunction

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic offer(input meas_t m);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    meas_x <= m.x;
    meas_y <= m.y;
    meas_length <= m.len;
    meas_heading <= m.hdg;
    do @(posedge clk); while (!in_ready);
    shadow.note_measurement(m);
    @(negedge clk);
  endtask

  // steady windows with random content, broken by outliers and noise runs
  task automatic send_runs(input int unsigned n_items, input int unsigned max_jit,
                           input bit neg_bias);
    int unsigned sent, run_len, jx, jy, jl, jh;
    logic signed [POS_W-1:0] bx, by;
    logic        [LEN_W-1:0] bl;
    logic signed [HDG_W-1:0] bh;
    meas_t m;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 7) begin
        bx = POS_W'(rand_bits(POS_W));
        by = POS_W'(rand_bits(POS_W));
        bl = LEN_W'(rand_bits(LEN_W));
        bh = HDG_W'(rand_bits(HDG_W));
        if (neg_bias) begin
          bx = POS_W'(-int'($urandom_range(1, 400000)));
          by = POS_W'(-int'($urandom_range(1, 400000)));
          bh = HDG_W'(-int'($urandom_range(1, 30000)));
        end
        jx = pick_jitter(max_jit);
        jy = pick_jitter(max_jit);
        jl = pick_jitter(max_jit);
        jh = pick_jitter(max_jit);
        run_len = $urandom_range(8, 16);
        repeat (run_len) begin
          if ($urandom_range(0, 11) == 0) begin
            m = noise_meas();
          end else begin
            m.x = POS_W'(around(longint'(bx), jx, longint'(POS_MIN), longint'(POS_MAX)));
            m.y = POS_W'(around(longint'(by), jy, longint'(POS_MIN), longint'(POS_MAX)));
            m.len = LEN_W'(around(longint'(bl), jl, longint'(0), longint'(LEN_MAX)));
            m.hdg = HDG_W'(around(longint'(bh), jh, longint'(HDG_MIN), longint'(HDG_MAX)));
          end
          offer(m);
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          offer(noise_meas());
          sent++;
        end
      end
    end
  endtask

  // length and heading swing between their extremes, spread at full scale
  task automatic send_extreme_swings(input int unsigned n_items);
    meas_t m;
    for (int i = 0; i < n_items; i++) begin
      m = noise_meas();
      m.len = (i % 2 == 0) ? '0 : LEN_MAX;
      m.hdg = (i % 2 == 0) ? HDG_MIN : HDG_MAX;
      offer(m);
    end
  endtask

  // drain the block, optionally write the unused indexes, then program the four limits
  task automatic reprogram_limits(input logic [LIM_W-1:0] xl, input logic [LIM_W-1:0] yl,
                                  input logic [LIM_W-1:0] ll, input logic [LIM_W-1:0] hl,
                                  input bit with_unused);
    cfg_write_t writes[$];
    in_valid <= 1'b0;
    while (shadow.pending() != 0) @(negedge clk);
    if (with_unused) begin
      for (int i = CFG_FIRST_UNUSED; i <= CFG_LAST_INDEX; i++)
        writes.insert(writes.size(), '{idx: CFG_IDX_W'(i), data: LIM_W'($urandom)});
    end
    writes.insert(writes.size(), '{idx: CFG_X_LIMIT, data: xl});
    writes.insert(writes.size(), '{idx: CFG_Y_LIMIT, data: yl});
    writes.insert(writes.size(), '{idx: CFG_LEN_LIMIT, data: ll});
    writes.insert(writes.size(), '{idx: CFG_HDG_LIMIT, data: hl});
    foreach (writes[k]) begin
      cfg_valid <= 1'b1;
      cfg_index <= writes[k].idx;
      cfg_data <= writes[k].data;
      do @(posedge clk); while (!cfg_ready);
      shadow.set_limit(writes[k].idx, writes[k].data);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    limit_sets++;
  endtask

  initial begin : stimulus
    meas_t m;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // corners under reset limits; the first request seeds the track
    for (int i = 0; i < 12; i++) begin
      case (i % 4)
        0: begin
          m.x = POS_MIN; m.y = POS_MAX; m.len = LEN_MAX; m.hdg = HDG_MIN;
        end
        1: begin
          m.x = POS_MAX; m.y = POS_MIN; m.len = '0; m.hdg = HDG_MAX;
        end
        2: begin
          m.x = -1; m.y = 1; m.len = 1; m.hdg = -1;
        end
        default: begin
          m.x = 3; m.y = -3; m.len = LEN_MAX - 16'd1; m.hdg = 7;
        end
      endcase
      offer(m);
    end

    // zero limits: nothing can latch, unused indexes must be ignored
    reprogram_limits('0, '0, '0, '0, 1'b1);
    send_runs(600, 2000, 1'b0);

    // x wide open but y closed, so the centre still cannot latch
    reprogram_limits('1, '0, '0, '0, 1'b0);
    no_gaps = 1'b1;
    send_runs(150, 2000, 1'b0);
    no_gaps = 1'b0;

    reprogram_limits(LIM_W'($urandom_range(1, 50)), '1, LIM_W'($urandom_range(1, 50)),
                     LIM_W'($urandom_range(1, 50)), 1'b0);
    send_runs(250, 400, 1'b0);
    send_extreme_swings(10);

    // full-scale limits on length and heading; a full-scale spread is not below
    reprogram_limits(LIM_W'($urandom_range(100, 2000)), LIM_W'($urandom_range(100, 2000)),
                     '1, '1, 1'b0);
    send_extreme_swings(6);
    send_runs(240, 40, 1'b1);

    in_valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d measurements sent and %0d tracks checked over %0d limit settings",
             shadow.noted, shadow.checked, limit_sets + 1);
    $display("latched at end: centre %0b, length %0b, heading %0b; %0d mismatches",
             shadow.centre_lat, shadow.len_lat, shadow.hdg_lat, shadow.errors);
    if (shadow.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : receiver
    rx_mode_t mode;
    int unsigned left, tick;
    mode = RX_ALWAYS;
    left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      // one long hold-off while the sender keeps offering
      if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_done = 1'b1;
      end
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        left = $urandom_range(16, 128);
      end
      left--;
      case (mode)
        RX_ALWAYS:       out_ready <= 1'b1;
        RX_COIN:         out_ready <= ($urandom_range(0, 1) == 1);
        RX_RARE_STALL:   out_ready <= ($urandom_range(0, 9) != 0);
        RX_EVERY_FOURTH: out_ready <= (tick % 4 == 0);
        default:         out_ready <= 1'b1;
      endcase
    end
  end

  initial begin : track_monitor
    track_t got;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.x = track_x;
        got.y = track_y;
        got.len = track_length;
        got.hdg = track_heading;
        got.centre = centre_stable;
        got.length = length_stable;
        got.heading = heading_stable;
        shadow.check_track(got);
        results_seen++;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t no request moved for %0d cycles", $time, STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

endmodule
